/* rtl/core/svepid_pkg.sv */
`timescale 1ns / 1ps

package svepid_pkg;

  // dense mnemonic numbers
  typedef enum logic [5:0] {
    OP_MLA     = 6'd0,
    OP_MLS     = 6'd1,
    OP_MAD     = 6'd2,
    OP_MSB     = 6'd3,
    OP_ADD     = 6'd4,
    OP_SUB     = 6'd5,
    OP_SUBR    = 6'd6,
    OP_SMAX    = 6'd7,
    OP_UMAX    = 6'd8,
    OP_SMIN    = 6'd9,
    OP_UMIN    = 6'd10,
    OP_SABD    = 6'd11,
    OP_UABD    = 6'd12,
    OP_MUL     = 6'd13,
    OP_SMULH   = 6'd14,
    OP_UMULH   = 6'd15,
    OP_SDIV    = 6'd16,
    OP_UDIV    = 6'd17,
    OP_SDIVR   = 6'd18,
    OP_UDIVR   = 6'd19,
    OP_ORR     = 6'd20,
    OP_EOR     = 6'd21,
    OP_AND     = 6'd22,
    OP_BIC     = 6'd23,
    OP_SADDV   = 6'd24,
    OP_UADDV   = 6'd25,
    OP_SMAXV   = 6'd26,
    OP_UMAXV   = 6'd27,
    OP_SMINV   = 6'd28,
    OP_UMINV   = 6'd29,
    OP_MOVPRFX = 6'd30,
    OP_ORV     = 6'd31,
    OP_EORV    = 6'd32,
    OP_ANDV    = 6'd33
  } op_id_t;

  // sve encoding prefix in bits 31:25
  localparam logic [6:0] SVE_PREFIX = 7'b0000010;

  // bits 15:13 group selects when bit 14 is clear
  localparam logic [2:0] GRP_ARITH  = 3'b000;
  localparam logic [2:0] GRP_REDUCE = 3'b001;

  // element size code for 64-bit elements
  localparam logic [1:0] SIZE_D = 2'd3;

  typedef logic [31:0] instr_t;

  typedef struct packed {
    logic       valid_res;
    logic [5:0] op_id;
    logic [1:0] elem_size;
    logic [2:0] pred_reg;
    logic [4:0] first_vreg;
    logic [4:0] second_vreg;
    logic [4:0] dest_vreg;
    logic       four_operands;
  } result_t;

endpackage

/* rtl/core/svepid_ifs.sv */
`timescale 1ns / 1ps

interface svepid_instr_if;
  logic                 valid;
  logic                 ready;
  svepid_pkg::instr_t   instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface svepid_result_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [5:0] op_id;
  logic [1:0] elem_size;
  logic [2:0] pred_reg;
  logic [4:0] first_vreg;
  logic [4:0] second_vreg;
  logic [4:0] dest_vreg;
  logic       four_operands;

  modport source (
    output valid, output valid_res, output op_id, output elem_size, output pred_reg,
    output first_vreg, output second_vreg, output dest_vreg, output four_operands,
    input ready
  );
  modport sink (
    input valid, input valid_res, input op_id, input elem_size, input pred_reg,
    input first_vreg, input second_vreg, input dest_vreg, input four_operands,
    output ready
  );
endinterface

/* rtl/core/svepid_in_reg.sv */
`timescale 1ns / 1ps

module svepid_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  svepid_pkg::instr_t in_word,
  output logic               q_valid,
  input  logic               q_ready,
  output svepid_pkg::instr_t q_word
);

  svepid_pkg::instr_t word;
  logic               full;

  assign in_ready = !full || q_ready;
  assign q_valid  = full;
  assign q_word   = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= in_word;
    end
  end

endmodule

/* rtl/core/svepid_decode.sv */
`timescale 1ns / 1ps

module svepid_decode (
  input  svepid_pkg::instr_t  w,
  output svepid_pkg::result_t res
);

  svepid_pkg::op_id_t id;
  logic               ok;
  logic               four;
  logic               sve;
  logic [2:0]         opc;
  logic [1:0]         sub;

  assign sve = (w[31:25] == svepid_pkg::SVE_PREFIX) && !w[24] && !w[21];
  assign opc = w[18:16];
  assign sub = w[20:19];

  always_comb begin
    id   = svepid_pkg::OP_MLA;
    ok   = 1'b0;
    four = 1'b0;
    if (w[14]) begin
      // multiply-add forms
      ok   = 1'b1;
      four = 1'b1;
      case ({w[15], w[13]})
        2'b00:   id = svepid_pkg::OP_MLA;
        2'b01:   id = svepid_pkg::OP_MLS;
        2'b10:   id = svepid_pkg::OP_MAD;
        default: id = svepid_pkg::OP_MSB;
      endcase
    end else if (w[15:13] == svepid_pkg::GRP_ARITH) begin
      case (sub)
        2'd0: begin
          ok = 1'b1;
          case (opc)
            3'd0:    id = svepid_pkg::OP_ADD;
            3'd1:    id = svepid_pkg::OP_SUB;
            3'd3:    id = svepid_pkg::OP_SUBR;
            default: ok = 1'b0;
          endcase
        end
        2'd1: begin
          ok = 1'b1;
          case (opc)
            3'd0:    id = svepid_pkg::OP_SMAX;
            3'd1:    id = svepid_pkg::OP_UMAX;
            3'd2:    id = svepid_pkg::OP_SMIN;
            3'd3:    id = svepid_pkg::OP_UMIN;
            3'd4:    id = svepid_pkg::OP_SABD;
            3'd5:    id = svepid_pkg::OP_UABD;
            default: ok = 1'b0;
          endcase
        end
        2'd2: begin
          if (!opc[2]) begin
            ok = 1'b1;
            case (opc[1:0])
              2'd0:    id = svepid_pkg::OP_MUL;
              2'd2:    id = svepid_pkg::OP_SMULH;
              2'd3:    id = svepid_pkg::OP_UMULH;
              default: ok = 1'b0;
            endcase
          end else begin
            // divide needs 32- or 64-bit elements
            ok = w[23];
            case (opc[1:0])
              2'd0:    id = svepid_pkg::OP_SDIV;
              2'd1:    id = svepid_pkg::OP_UDIV;
              2'd2:    id = svepid_pkg::OP_SDIVR;
              default: id = svepid_pkg::OP_UDIVR;
            endcase
          end
        end
        default: begin
          ok = !opc[2];
          case (opc[1:0])
            2'd0:    id = svepid_pkg::OP_ORR;
            2'd1:    id = svepid_pkg::OP_EOR;
            2'd2:    id = svepid_pkg::OP_AND;
            default: id = svepid_pkg::OP_BIC;
          endcase
        end
      endcase
    end else if (w[15:13] == svepid_pkg::GRP_REDUCE) begin
      case (sub)
        2'd0: begin
          ok = 1'b1;
          case (opc)
            // no signed add reduction on 64-bit elements
            3'd0:    begin
              id = svepid_pkg::OP_SADDV;
              ok = (w[23:22] != svepid_pkg::SIZE_D);
            end
            3'd1:    id = svepid_pkg::OP_UADDV;
            default: ok = 1'b0;
          endcase
        end
        2'd1: begin
          ok = !opc[2];
          case (opc[1:0])
            2'd0:    id = svepid_pkg::OP_SMAXV;
            2'd1:    id = svepid_pkg::OP_UMAXV;
            2'd2:    id = svepid_pkg::OP_SMINV;
            default: id = svepid_pkg::OP_UMINV;
          endcase
        end
        2'd2: begin
          // merge/zero bit 16 is ignored
          id = svepid_pkg::OP_MOVPRFX;
          ok = (opc[2:1] == 2'b00);
        end
        default: begin
          ok = 1'b1;
          case (opc)
            3'd0:    id = svepid_pkg::OP_ORV;
            3'd1:    id = svepid_pkg::OP_EORV;
            3'd2:    id = svepid_pkg::OP_ANDV;
            default: ok = 1'b0;
          endcase
        end
      endcase
    end
  end

  always_comb begin
    res = '0;
    if (sve && ok) begin
      res.valid_res     = 1'b1;
      res.op_id         = id;
      res.elem_size     = w[23:22];
      res.pred_reg      = w[12:10];
      res.first_vreg    = four ? w[20:16] : w[9:5];
      res.second_vreg   = four ? w[9:5] : 5'd0;
      res.dest_vreg     = w[4:0];
      res.four_operands = four;
    end
  end

endmodule

/* rtl/core/sve_predicated_int_decoder_unit.sv */
`timescale 1ns / 1ps

// Predicated integer SVE decoder: each transfer on instr_ch carries one
// 32-bit instruction word and produces exactly one transfer on result_ch,
// in order, giving the mnemonic id (0 to 33), element size, governing
// predicate and vector register numbers; a word outside the supported
// groups comes back with every field zero. The word is captured in an
// input register, decoded by a shallow layer of bit-field logic and held
// in a result register, which drives result_ch. One word per cycle is
// sustained while result_ch stays ready: both registers load whenever they
// are empty or their contents move on in the same cycle, so a stalled
// result does not stop the input side until both registers are full.
module sve_predicated_int_decoder_unit (
  input  logic     clk,
  input  logic     rst,
  svepid_instr_if.sink    instr_ch,
  svepid_result_if.source result_ch
);

  // input register to decode stage
  logic                q_valid;
  logic                q_ready;
  svepid_pkg::instr_t  q_word;

  // decoded result and result register
  svepid_pkg::result_t dec;
  svepid_pkg::result_t res;
  logic                res_full;

  svepid_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (instr_ch.valid),
    .in_ready (instr_ch.ready),
    .in_word  (instr_ch.instr_word),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_word   (q_word)
  );

  // pure bit-field decode between the two registers
  svepid_decode u_decode (
    .w   (q_word),
    .res (dec)
  );

  // result register takes a new word when empty or being drained
  assign q_ready = !res_full || result_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (q_ready) begin
      res_full <= q_valid;
    end
  end

  // payload carries no reset
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      res <= dec;
    end
  end

  assign result_ch.valid         = res_full;
  assign result_ch.valid_res     = res.valid_res;
  assign result_ch.op_id         = res.op_id;
  assign result_ch.elem_size     = res.elem_size;
  assign result_ch.pred_reg      = res.pred_reg;
  assign result_ch.first_vreg    = res.first_vreg;
  assign result_ch.second_vreg   = res.second_vreg;
  assign result_ch.dest_vreg     = res.dest_vreg;
  assign result_ch.four_operands = res.four_operands;

endmodule

/* tb/sve_predicated_int_decoder_unit_tb.sv */
`timescale 1ns / 1ps

module sve_predicated_int_decoder_unit_tb;

  // split on bits 20:19, shared by the arithmetic and the reduction groups
  localparam logic [1:0] SEL_ADDSUB = 2'b00;
  localparam logic [1:0] SEL_MINMAX = 2'b01;
  localparam logic [1:0] SEL_MULDIV = 2'b10;
  localparam logic [1:0] SEL_LOGIC  = 2'b11;

  // bits 15:13 for the multiply-add forms and the groups left undecoded
  localparam logic [2:0] GRP_MLA   = 3'b010;
  localparam logic [2:0] GRP_MLS   = 3'b011;
  localparam logic [2:0] GRP_MAD   = 3'b110;
  localparam logic [2:0] GRP_MSB   = 3'b111;
  localparam logic [2:0] GRP_SHIFT = 3'b100;
  localparam logic [2:0] GRP_UNARY = 3'b101;

  localparam int NUM_RANDOM = 1870;
  localparam int HOLD_CYCLES = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;

  svepid_instr_if  instr_ch ();
  svepid_result_if result_ch ();

  sve_predicated_int_decoder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .instr_ch  (instr_ch),
    .result_ch (result_ch)
  );

  always #4 clk = ~clk;

  svepid_pkg::instr_t  word_queue[$];        // words still to be offered
  svepid_pkg::result_t expected_decodes[$];  // decodes of accepted words, oldest first
  int      n_words = 0;
  int      words_in = 0;
  int      results_out = 0;
  int      mismatch_cnt = 0;
  int      send_gap = 0;
  int      recv_stall = 0;
  logic    hold_off = 1'b0;

  // decode of one word: every field zero unless the word is a supported form
  function automatic svepid_pkg::result_t decode_word(svepid_pkg::instr_t w);
    svepid_pkg::result_t r;
    svepid_pkg::op_id_t  id;
    logic       ok;
    logic [2:0] opc;
    logic [1:0] sz;
    r   = '0;
    id  = svepid_pkg::OP_MLA;
    ok  = 1'b0;
    opc = w[18:16];
    sz  = w[23:22];
    // not in the sve predicated integer space at all
    if (w[31:25] != svepid_pkg::SVE_PREFIX || w[24] || w[21]) return r;
    r.first_vreg = w[9:5];
    if (w[14]) begin
      // multiply-add: bit 15 picks mad/msb over mla/mls, bit 13 the subtract
      ok = 1'b1;
      id = svepid_pkg::op_id_t'(svepid_pkg::OP_MLA + {w[15], w[13]});
      r.four_operands = 1'b1;
      r.second_vreg   = w[9:5];
      r.first_vreg    = w[20:16];
    end else if (w[15:13] == svepid_pkg::GRP_ARITH) begin
      case (w[20:19])
        SEL_ADDSUB: begin
          ok = 1'b1;
          case (opc)
            3'd0: id = svepid_pkg::OP_ADD;
            3'd1: id = svepid_pkg::OP_SUB;
            3'd3: id = svepid_pkg::OP_SUBR;
            default: ok = 1'b0;
          endcase
        end
        SEL_MINMAX: begin
          ok = (opc < 3'd6);
          id = svepid_pkg::op_id_t'(svepid_pkg::OP_SMAX + opc);
        end
        SEL_MULDIV: begin
          if (!w[18]) begin
            ok = 1'b1;
            case (w[17:16])
              2'b00: id = svepid_pkg::OP_MUL;
              2'b10: id = svepid_pkg::OP_SMULH;
              2'b11: id = svepid_pkg::OP_UMULH;
              default: ok = 1'b0;
            endcase
          end else begin
            // divide only exists for 32 and 64 bit elements
            ok = sz[1];
            id = svepid_pkg::op_id_t'(svepid_pkg::OP_SDIV + w[17:16]);
          end
        end
        default: begin
          ok = !opc[2];
          id = svepid_pkg::op_id_t'(svepid_pkg::OP_ORR + opc[1:0]);
        end
      endcase
    end else if (w[15:13] == svepid_pkg::GRP_REDUCE) begin
      case (w[20:19])
        SEL_ADDSUB: begin
          // no signed add reduction at 64 bits
          ok = (opc[2:1] == 2'b00) && !(opc[0] == 1'b0 && sz == svepid_pkg::SIZE_D);
          id = svepid_pkg::op_id_t'(svepid_pkg::OP_SADDV + opc[0]);
        end
        SEL_MINMAX: begin
          ok = !opc[2];
          id = svepid_pkg::op_id_t'(svepid_pkg::OP_SMAXV + opc[1:0]);
        end
        SEL_MULDIV: begin
          // movprfx, the zeroing/merging bit 16 does not matter
          ok = (w[18:17] == 2'b00);
          id = svepid_pkg::OP_MOVPRFX;
        end
        default: begin
          ok = (opc < 3'd3);
          id = svepid_pkg::op_id_t'(svepid_pkg::OP_ORV + opc[1:0]);
        end
      endcase
    end
    if (!ok) return '0;
    r.valid_res = 1'b1;
    r.op_id     = id;
    r.elem_size = sz;
    r.pred_reg  = w[12:10];
    r.dest_vreg = w[4:0];
    return r;
  endfunction

  // hi5 lands in bits 20:19 and the opcode bits 18:16, lo13 in pg, zn, zd
  function automatic svepid_pkg::instr_t sve_word(logic [1:0] sz, logic [4:0] hi5,
                                                  logic [2:0] grp, logic [12:0] lo13);
    return {svepid_pkg::SVE_PREFIX, 1'b0, sz, 1'b0, hi5, grp, lo13};
  endfunction

  function automatic svepid_pkg::instr_t random_word();
    svepid_pkg::instr_t w;
    int unsigned k;
    int unsigned j;
    w = $urandom();
    k = $urandom_range(0, 99);
    if (k < 80) begin
      // well formed prefix, group steered toward the decoded spaces
      w[31:25] = svepid_pkg::SVE_PREFIX;
      w[24]    = 1'b0;
      w[21]    = 1'b0;
      case ($urandom_range(0, 3))
        0: w[15:13] = svepid_pkg::GRP_ARITH;
        1: w[15:13] = svepid_pkg::GRP_REDUCE;
        2: w[14] = 1'b1;
        default: ;
      endcase
    end else if (k < 92) begin
      // one bit off the prefix, or bit 24 or bit 21 set
      w[31:25] = svepid_pkg::SVE_PREFIX;
      w[24]    = 1'b0;
      w[21]    = 1'b0;
      j = $urandom_range(0, 8);
      if (j < 8) w[24 + j] = ~w[24 + j];
      else w[21] = 1'b1;
    end
    return w;
  endfunction

  // idle length: mostly none or short, now and then long, none in quiet phases
  function automatic int pick_gap(logic quiet);
    int unsigned k;
    k = $urandom_range(0, 99);
    if (quiet || k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender: offers the queued words, holding each until its transfer
  always @(posedge clk) begin
    if (rst) begin
      instr_ch.valid <= 1'b0;
      send_gap       <= 0;
    end else begin
      if (instr_ch.valid && instr_ch.ready) begin
        expected_decodes.push_back(decode_word(instr_ch.instr_word));
        words_in++;
      end
      if (!instr_ch.valid || instr_ch.ready) begin
        if (send_gap != 0) begin
          instr_ch.valid <= 1'b0;
          send_gap       <= send_gap - 1;
        end else if (word_queue.size() != 0) begin
          instr_ch.valid      <= 1'b1;
          instr_ch.instr_word <= word_queue.pop_front();
          send_gap            <= pick_gap((words_in / 128) % 4 == 3);
        end else begin
          instr_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transfer against the oldest decode
  always @(posedge clk) begin : result_check
    svepid_pkg::result_t got;
    svepid_pkg::result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_stall      <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = {result_ch.valid_res, result_ch.op_id, result_ch.elem_size,
               result_ch.pred_reg, result_ch.first_vreg, result_ch.second_vreg,
               result_ch.dest_vreg, result_ch.four_operands};
        results_out++;
        if (expected_decodes.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result with nothing outstanding: %p", $realtime, got);
        end else begin
          want = expected_decodes.pop_front();
          if (got.valid_res !== want.valid_res || got.op_id !== want.op_id ||
              got.elem_size !== want.elem_size || got.pred_reg !== want.pred_reg ||
              got.first_vreg !== want.first_vreg || got.second_vreg !== want.second_vreg ||
              got.dest_vreg !== want.dest_vreg || got.four_operands !== want.four_operands) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: result %0d mismatch\n  expected %p\n  actual   %p",
                       $realtime, results_out, want, got);
          end
        end
      end
      // long hold-off wins, otherwise random stalls with quiet phases
      if (hold_off) begin
        result_ch.ready <= 1'b0;
      end else if (recv_stall != 0) begin
        result_ch.ready <= 1'b0;
        recv_stall      <= recv_stall - 1;
      end else begin
        result_ch.ready <= 1'b1;
        recv_stall      <= pick_gap((results_out / 96) % 4 == 1);
      end
    end
  end

  // back-pressure: receiver stops for a long stretch while words keep coming
  initial begin
    wait (words_in >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    instr_ch.valid      = 1'b0;
    instr_ch.instr_word = '0;
    result_ch.ready     = 1'b0;

    // directed: field extremes, each group and the rejected encodings
    word_queue.push_back(32'h0000_0000);
    word_queue.push_back(32'hFFFF_FFFF);
    word_queue.push_back(sve_word(2'd3, 5'h1F, GRP_MLA, 13'h1FFF));
    word_queue.push_back(sve_word(2'd0, 5'h00, GRP_MLS, 13'h0000));
    word_queue.push_back(sve_word(2'd1, 5'h15, GRP_MAD, 13'h0AB5));
    word_queue.push_back(sve_word(2'd2, 5'h0A, GRP_MSB, 13'h154A));
    word_queue.push_back(sve_word(2'd3, {SEL_ADDSUB, 3'd0}, svepid_pkg::GRP_ARITH, 13'h1FFF));
    word_queue.push_back(sve_word(2'd0, {SEL_ADDSUB, 3'd3}, svepid_pkg::GRP_ARITH, 13'h0421));
    word_queue.push_back(sve_word(2'd1, {SEL_ADDSUB, 3'd2}, svepid_pkg::GRP_ARITH, 13'h0C63));
    word_queue.push_back(sve_word(2'd2, {SEL_MINMAX, 3'd5}, svepid_pkg::GRP_ARITH, 13'h18C6));
    word_queue.push_back(sve_word(2'd2, {SEL_MINMAX, 3'd6}, svepid_pkg::GRP_ARITH, 13'h18C6));
    word_queue.push_back(sve_word(2'd3, {SEL_MULDIV, 3'd3}, svepid_pkg::GRP_ARITH, 13'h1234));
    word_queue.push_back(sve_word(2'd0, {SEL_MULDIV, 3'd1}, svepid_pkg::GRP_ARITH, 13'h0F0F));
    word_queue.push_back(sve_word(2'd2, {SEL_MULDIV, 3'd4}, svepid_pkg::GRP_ARITH, 13'h0155));
    word_queue.push_back(sve_word(2'd3, {SEL_MULDIV, 3'd7}, svepid_pkg::GRP_ARITH, 13'h1AAA));
    word_queue.push_back(sve_word(2'd1, {SEL_MULDIV, 3'd5}, svepid_pkg::GRP_ARITH, 13'h1AAA));
    word_queue.push_back(sve_word(2'd1, {SEL_LOGIC, 3'd3}, svepid_pkg::GRP_ARITH, 13'h0777));
    word_queue.push_back(sve_word(2'd1, {SEL_LOGIC, 3'd4}, svepid_pkg::GRP_ARITH, 13'h0777));
    word_queue.push_back(sve_word(2'd3, {SEL_ADDSUB, 3'd0}, svepid_pkg::GRP_REDUCE, 13'h1C1F));
    word_queue.push_back(sve_word(2'd3, {SEL_ADDSUB, 3'd1}, svepid_pkg::GRP_REDUCE, 13'h1C1F));
    word_queue.push_back(sve_word(2'd0, {SEL_MINMAX, 3'd2}, svepid_pkg::GRP_REDUCE, 13'h03E0));
    word_queue.push_back(sve_word(2'd2, {SEL_MULDIV, 3'd1}, svepid_pkg::GRP_REDUCE, 13'h0E31));
    word_queue.push_back(sve_word(2'd2, {SEL_MULDIV, 3'd2}, svepid_pkg::GRP_REDUCE, 13'h0E31));
    word_queue.push_back(sve_word(2'd1, {SEL_LOGIC, 3'd2}, svepid_pkg::GRP_REDUCE, 13'h1111));
    word_queue.push_back(sve_word(2'd1, {SEL_LOGIC, 3'd3}, svepid_pkg::GRP_REDUCE, 13'h1111));
    word_queue.push_back(sve_word(2'd2, {SEL_ADDSUB, 3'd0}, GRP_SHIFT, 13'h0842));
    word_queue.push_back(sve_word(2'd2, {SEL_ADDSUB, 3'd0}, GRP_UNARY, 13'h0842));
    word_queue.push_back(sve_word(2'd0, {SEL_ADDSUB, 3'd0}, svepid_pkg::GRP_ARITH, 13'h0001)
                         | (32'h1 << 24));
    word_queue.push_back(sve_word(2'd0, {SEL_ADDSUB, 3'd0}, svepid_pkg::GRP_ARITH, 13'h0001)
                         | (32'h1 << 21));

    for (int i = 0; i < NUM_RANDOM; i++)
      word_queue.push_back(random_word());

    n_words = word_queue.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // every word sent and every result back, then a drain before the final check
    wait (results_out >= n_words);
    repeat (6) @(posedge clk);

    if (mismatch_cnt == 0 && expected_decodes.size() == 0 && results_out == n_words) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sve_predicated_int_decoder_unit.f */
rtl/core/svepid_pkg.sv
rtl/core/svepid_ifs.sv
rtl/core/svepid_in_reg.sv
rtl/core/svepid_decode.sv
rtl/core/sve_predicated_int_decoder_unit.sv
tb/sve_predicated_int_decoder_unit_tb.sv
